### sv/mpq_pkg.sv
// Shared types and constants for the linear-scan max priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package mpq_pkg;

   localparam int DEPTH = 1024;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int STATUS_W = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE
   } state_type;

   // Control from the sequencer to the shared compare unit.
   typedef struct packed {
      logic             load;
      logic             enable;
      logic [IDX_W-1:0] idx;
   } scan_ctrl_type;

endpackage

`default_nettype wire

### sv/max_priority_queue_linear_scan_top.sv
// Top level of the linear-scan max priority queue: sequencer, count and result.
// Depends on mpq_pkg, mpq_store and mpq_max_unit.
`default_nettype none

// Usage:
// An item is taken at a clock edge with start high and busy low. req_operation
// selects insert or remove; req_value is the value to insert.
// Every item gives exactly one result, shown for one cycle with rsp_valid high:
// rsp_removed_value, rsp_status and rsp_occupancy (entries stored afterward).
// An insert, an insert into a full queue and a remove from an empty queue
// are handled in the idle state; the result is registered and shows in the
// next cycle, and busy stays low, so such items may be given back to back.
// A remove with n stored entries reads the store one entry per cycle through
// the shared compare unit; busy stays high through the scan and the write-back,
// and the result shows in the cycle after the write-back. The store has a
// single read port, so the scan reads one entry at a time.
// Reset empties the queue; stored data is not cleared. The receiver cannot
// stall: each result is taken in the cycle it is shown.

module max_priority_queue_linear_scan_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_operation,
   input  wire logic [mpq_pkg::VAL_W-1:0]    req_value,
   output logic                              rsp_valid,
   output logic      [mpq_pkg::VAL_W-1:0]    rsp_removed_value,
   output logic      [mpq_pkg::STATUS_W-1:0] rsp_status,
   output logic      [mpq_pkg::CNT_W-1:0]    rsp_occupancy
);
   import mpq_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    count_ff;
   logic [IDX_W-1:0]    ptr_ff;
   logic [IDX_W-1:0]    data_idx_ff;
   logic [VAL_W-1:0]    last_ff;
   logic                rsp_valid_ff;
   logic [VAL_W-1:0]    rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic             accept;
   logic             is_full;
   logic             is_empty;
   logic             scan_last;
   logic [CNT_W-1:0] count_less;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [VAL_W-1:0] rd_data;
   logic [VAL_W-1:0] best_val;
   logic [IDX_W-1:0] best_idx;
   scan_ctrl_type    scan_ctrl;

   assign accept     = start && !busy;
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign count_less = count_ff - CNT_W'(1);
   assign scan_last  = (data_idx_ff == count_less[IDX_W-1:0]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_operation == OP_REMOVE) && !is_empty) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_last) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      busy             = 1'b1;
      wr_en            = 1'b0;
      wr_addr          = count_ff[IDX_W-1:0];
      wr_data          = req_value;
      rd_addr          = ptr_ff;
      scan_ctrl.load   = 1'b0;
      scan_ctrl.enable = 1'b0;
      scan_ctrl.idx    = data_idx_ff;
      case (state_ff)
         S_IDLE: begin
            busy    = 1'b0;
            rd_addr = '0;
            wr_en   = accept && (req_operation == OP_INSERT) && !is_full;
         end
         S_SCAN: begin
            scan_ctrl.load   = (data_idx_ff == '0);
            scan_ctrl.enable = 1'b1;
         end
         S_WRITE: begin
            // The last entry fills the slot of the removed one.
            wr_en   = 1'b1;
            wr_addr = best_idx;
            wr_data = last_ff;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_operation == OP_INSERT) begin
                     rsp_valid_ff <= 1'b1;
                     if (!is_full) begin
                        count_ff <= count_ff + CNT_W'(1);
                     end
                  end else if (is_empty) begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_WRITE: begin
               rsp_valid_ff <= 1'b1;
               count_ff     <= count_less;
            end
            default: begin
               count_ff <= count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_idx_ff <= rd_addr;
      if (state_ff == S_IDLE) begin
         ptr_ff <= IDX_W'(1);
      end else begin
         ptr_ff <= ptr_ff + IDX_W'(1);
      end
      if (state_ff == S_SCAN) begin
         last_ff <= rd_data;
      end
      if (state_ff == S_WRITE) begin
         rsp_value_ff  <= best_val;
         rsp_status_ff <= STATUS_OK;
      end else if (accept) begin
         if (req_operation == OP_INSERT) begin
            rsp_value_ff  <= '0;
            rsp_status_ff <= is_full ? STATUS_FULL : STATUS_OK;
         end else begin
            rsp_value_ff  <= '1;
            rsp_status_ff <= STATUS_EMPTY;
         end
      end
   end

   mpq_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mpq_max_unit u_max (
      .clock    (clock),
      .ctrl     (scan_ctrl),
      .data     (rd_data),
      .best_val (best_val),
      .best_idx (best_idx)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_occupancy     = count_ff;

endmodule

`default_nettype wire

### sv/mpq_store.sv
// Entry storage: one write port and one read port with registered read data.
// Depends on mpq_pkg.
`default_nettype none

module mpq_store (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [mpq_pkg::IDX_W-1:0] wr_addr,
   input  wire logic [mpq_pkg::VAL_W-1:0] wr_data,
   input  wire logic [mpq_pkg::IDX_W-1:0] rd_addr,
   output logic      [mpq_pkg::VAL_W-1:0] rd_data
);
   import mpq_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### sv/mpq_max_unit.sv
// Shared signed compare unit that tracks the largest entry seen during a scan.
// Depends on mpq_pkg.
`default_nettype none

module mpq_max_unit (
   input  wire logic                           clock,
   input  wire mpq_pkg::scan_ctrl_type         ctrl,
   input  wire logic      [mpq_pkg::VAL_W-1:0] data,
   output logic           [mpq_pkg::VAL_W-1:0] best_val,
   output logic           [mpq_pkg::IDX_W-1:0] best_idx
);
   import mpq_pkg::*;

   logic [VAL_W-1:0] best_val_ff;
   logic [IDX_W-1:0] best_idx_ff;

   // A strict greater-than keeps the lowest index on ties.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         best_val_ff <= data;
         best_idx_ff <= ctrl.idx;
      end else if (ctrl.enable && ($signed(data) > $signed(best_val_ff))) begin
         best_val_ff <= data;
         best_idx_ff <= ctrl.idx;
      end
   end

   assign best_val = best_val_ff;
   assign best_idx = best_idx_ff;

endmodule

`default_nettype wire
